[rtl/core/c2d_pkg.sv]
// ============================================================================
// c2d_pkg: shared types and constants of the 2-D convolution block
// Operation codes, register indexes, controller state type, the control
// bundle between the controller and the MAC datapath, and saturation bounds.
// ============================================================================
package c2d_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_TAP   = 2'd1;
    localparam logic [1:0] OP_CONV  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_IMG_H    = 3'd1;
    localparam logic [2:0] CFG_IMG_W    = 3'd2;
    localparam logic [2:0] CFG_KER_H    = 3'd3;
    localparam logic [2:0] CFG_KER_W    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic       RST_MODE  = 1'b1;
    localparam logic [5:0] RST_IMG_H = 6'd32;
    localparam logic [5:0] RST_IMG_W = 6'd32;
    localparam logic [3:0] RST_KER_H = 4'd3;
    localparam logic [3:0] RST_KER_W = 4'd3;

    // Result range, Q24.16 in 40 bits.
    localparam logic signed [39:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] SUM_MIN = 40'sh80_0000_0000;

    // Small signed type for window geometry; holds every dimension and offset.
    typedef logic signed [9:0] t_sv;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_DRAIN
    } t_state;

    // Control bundle from the controller to the MAC datapath.
    typedef struct packed {
        logic wr_img;    // write one pixel
        logic wr_ker;    // write one tap
        logic issue;     // read one pixel/tap pair for the window
        logic acc_init;  // load the accumulator with the addend
    } t_mac_ctrl;

endpackage

[rtl/core/c2d_mac.sv]
// ============================================================================
// c2d_mac: pixel and tap stores with a multiply-accumulate pipeline
// Both stores are single-port synchronous memories with registered read
// data. Each issued pair flows through read, multiply and accumulate stages.
// ============================================================================
module c2d_mac
    import c2d_pkg::*;
#(
    parameter int MAX_IMAGE_DIM  = 32,
    parameter int MAX_KERNEL_DIM = 8,
    parameter int IMG_AW         = 10,
    parameter int KER_AW         = 6,
    parameter int ACC_W          = 48
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctrl               i_ctrl,
    input  logic [IMG_AW-1:0]       i_img_wr_addr,
    input  logic [KER_AW-1:0]       i_ker_wr_addr,
    input  logic signed [15:0]      i_wr_data,
    input  logic [IMG_AW-1:0]       i_img_rd_addr,
    input  logic [KER_AW-1:0]       i_ker_rd_addr,
    input  logic signed [ACC_W-1:0] i_acc_init,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_busy
);

    localparam int IMG_DEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int KER_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;

    logic signed [15:0] img_mem [IMG_DEPTH];
    logic signed [15:0] ker_mem [KER_DEPTH];

    logic signed [15:0]      r_pix;
    logic signed [15:0]      r_tap;
    logic signed [31:0]      r_prod;
    logic                    r_rd_v;
    logic                    r_prod_v;
    logic signed [ACC_W-1:0] r_acc;

    // Loads happen only while the controller is idle and reads only while it
    // runs a window, so a store never sees a read and a write in one cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_img) begin
            img_mem[i_img_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.issue) begin
            r_pix <= img_mem[i_img_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_ker) begin
            ker_mem[i_ker_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.issue) begin
            r_tap <= ker_mem[i_ker_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_pix * r_tap;
        if (i_ctrl.acc_init) begin
            r_acc <= i_acc_init;
        end else if (r_prod_v) begin
            r_acc <= r_acc + {{(ACC_W-32){r_prod[31]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_ctrl.issue;
            r_prod_v <= r_rd_v;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_rd_v | r_prod_v;

endmodule

[rtl/core/conv2d_full_valid_top.sv]
// ============================================================================
// conv2d_full_valid_top: 2-D true convolution, full or valid output region
// Loads pixels and taps into on-chip stores and computes one output position
// per compute word: the addend plus the edge-clipped window sum, saturated.
// ============================================================================
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   ---------------------------------
//  input     start & !busy                i_op, i_row, i_col, i_sample,
//                                         i_addend
//  result    o_done (one-cycle strobe)    o_sum, o_range_error
//  config    i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// A pixel or tap load word is written into its store at the accepting
// edge; busy stays low, so loads can stream back to back.
// A compute word passes a setup state, one store read per tap of the
// clipped window (at most MAX_KERNEL_DIM squared taps), a drain state that
// waits until the read and multiply stages are empty, a register for the
// saturated result and the result strobe; busy stays high until the strobe.
// A position outside the output region is answered from the setup state
// without any store read. The single read port of each store, one pair a
// cycle, paces the store reads.
// Reset is synchronous and active low; it returns the configuration
// registers to their defaults and idles the controller. Store contents are
// not cleared. The result is held for exactly one cycle and cannot be
// stalled by the receiver; the configuration port is always ready.
//
module conv2d_full_valid_top
    import c2d_pkg::*;
#(
    parameter int MAX_IMAGE_DIM  = 32,
    parameter int MAX_KERNEL_DIM = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input words
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic signed [15:0] i_sample,
    input  logic signed [39:0] i_addend,
    // Results
    output logic               o_done,
    output logic signed [39:0] o_sum,
    output logic               o_range_error,
    // Configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data
);

    localparam int IMG_AW = $clog2(MAX_IMAGE_DIM * MAX_IMAGE_DIM);
    localparam int KER_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int KER_AW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
    localparam int IW  = $clog2(MAX_IMAGE_DIM);
    localparam int KIW = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
    // Window sum of up to MAX_KERNEL_DIM^2 Q16.16 products plus a Q24.16 addend.
    localparam int ACC_W = 42 + $clog2(KER_DEPTH);

    localparam t_sv MAX_IMG_S = t_sv'(MAX_IMAGE_DIM);
    localparam t_sv MAX_KER_S = t_sv'(MAX_KERNEL_DIM);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-40){SUM_MAX[39]}}, SUM_MAX};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-40){SUM_MIN[39]}}, SUM_MIN};

    // Configuration registers.
    logic       r_mode;
    logic [5:0] r_img_h;
    logic [5:0] r_img_w;
    logic [3:0] r_ker_h;
    logic [3:0] r_ker_w;

    // Controller.
    t_state r_state;
    t_state n_state;

    // Captured compute word.
    logic [5:0]         r_row;
    logic [5:0]         r_col;
    logic signed [39:0] r_addend;

    // Window sequencer: image and kernel coordinates of the current tap.
    logic [IW-1:0]  r_ir;
    logic [IW-1:0]  r_ic;
    logic [IW-1:0]  r_ir_last;
    logic [IW-1:0]  r_ic_last;
    logic [IW-1:0]  r_ic_first;
    logic [KIW-1:0] r_kr;
    logic [KIW-1:0] r_kc;
    logic [KIW-1:0] r_kc_first;

    // Result registers.
    logic               r_done;
    logic signed [39:0] r_sum;
    logic               r_rerr;

    // Datapath interface.
    t_mac_ctrl               mac_ctrl;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_busy;
    logic [IMG_AW-1:0]       img_wr_addr;
    logic [KER_AW-1:0]       ker_wr_addr;
    logic [IMG_AW-1:0]       img_rd_addr;
    logic [KER_AW-1:0]       ker_rd_addr;

    // Setup geometry.
    t_sv  h1, w1, h2, w2;
    t_sv  rows, cols, oi, oj;
    t_sv  ps, pe, qs, qe;
    t_sv  ir0, ir_end, kr0, ic0, ic_end, kc0;
    logic pos_err;
    logic win_empty;

    logic accept;
    logic last_tap;
    logic img_in_range;
    logic ker_in_range;
    logic signed [39:0] sat_sum;

    function automatic t_sv clamp_dim(input logic [5:0] v, input t_sv maxv);
        t_sv x;
        x = t_sv'({4'b0000, v});
        if (x < 10'sd1) begin
            x = 10'sd1;
        end else if (x > maxv) begin
            x = maxv;
        end
        return x;
    endfunction

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_img_h <= RST_IMG_H;
            r_img_w <= RST_IMG_W;
            r_ker_h <= RST_KER_H;
            r_ker_w <= RST_KER_W;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_IMG_H: r_img_h <= i_cfg_data;
                CFG_IMG_W: r_img_w <= i_cfg_data;
                CFG_KER_H: r_ker_h <= i_cfg_data[3:0];
                CFG_KER_W: r_ker_w <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Window geometry, evaluated in the setup cycle from the captured word.
    // The window is clipped to the image, so the pixel and tap ranges
    // start and end where the rotated kernel leaves the image.
    // ------------------------------------------------------------------
    always_comb begin
        h1 = clamp_dim(r_img_h, MAX_IMG_S);
        w1 = clamp_dim(r_img_w, MAX_IMG_S);
        h2 = clamp_dim({2'b00, r_ker_h}, MAX_KER_S);
        w2 = clamp_dim({2'b00, r_ker_w}, MAX_KER_S);

        if (r_mode) begin
            rows = h1 + h2 - 10'sd1;
            cols = w1 + w2 - 10'sd1;
            oi   = t_sv'({4'b0000, r_row}) - (h2 - 10'sd1);
            oj   = t_sv'({4'b0000, r_col}) - (w2 - 10'sd1);
        end else begin
            rows = h1 - h2 + 10'sd1;
            cols = w1 - w2 + 10'sd1;
            oi   = t_sv'({4'b0000, r_row});
            oj   = t_sv'({4'b0000, r_col});
        end

        pos_err = (t_sv'({4'b0000, r_row}) >= rows) || (t_sv'({4'b0000, r_col}) >= cols);

        ps = (oi < 10'sd0) ? -oi : 10'sd0;
        pe = (h2 < h1 - oi) ? h2 : h1 - oi;
        qs = (oj < 10'sd0) ? -oj : 10'sd0;
        qe = (w2 < w1 - oj) ? w2 : w1 - oj;

        win_empty = (pe <= ps) || (qe <= qs);

        ir0    = oi + ps;
        ir_end = oi + pe - 10'sd1;
        kr0    = h2 - 10'sd1 - ps;
        ic0    = oj + qs;
        ic_end = oj + qe - 10'sd1;
        kc0    = w2 - 10'sd1 - qs;
    end

    // ------------------------------------------------------------------
    // Controller: next state
    // ------------------------------------------------------------------
    assign last_tap = (r_ir == r_ir_last) && (r_ic == r_ic_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_CONV)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (pos_err) begin
                    n_state = S_IDLE;
                end else if (win_empty) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!mac_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Controller: outputs to the datapath
    // ------------------------------------------------------------------
    assign img_in_range = ({4'b0000, i_row} < 10'(MAX_IMAGE_DIM))
                       && ({4'b0000, i_col} < 10'(MAX_IMAGE_DIM));
    assign ker_in_range = ({4'b0000, i_row} < 10'(MAX_KERNEL_DIM))
                       && ({4'b0000, i_col} < 10'(MAX_KERNEL_DIM));

    always_comb begin
        mac_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                mac_ctrl.wr_img = accept && (i_op == OP_PIXEL) && img_in_range;
                mac_ctrl.wr_ker = accept && (i_op == OP_TAP) && ker_in_range;
            end
            S_SETUP: begin
                mac_ctrl.acc_init = 1'b1;
            end
            S_RUN: begin
                mac_ctrl.issue = 1'b1;
            end
            default: ;
        endcase
    end

    // Store addresses, row-major. Write addresses are only used in range.
    assign img_wr_addr = IMG_AW'(i_row) * IMG_AW'(MAX_IMAGE_DIM) + IMG_AW'(i_col);
    assign ker_wr_addr = KER_AW'(i_row) * KER_AW'(MAX_KERNEL_DIM) + KER_AW'(i_col);
    assign img_rd_addr = IMG_AW'(r_ir) * IMG_AW'(MAX_IMAGE_DIM) + IMG_AW'(r_ic);
    assign ker_rd_addr = KER_AW'(r_kr) * KER_AW'(MAX_KERNEL_DIM) + KER_AW'(r_kc);

    // ------------------------------------------------------------------
    // Captured word and window sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row    <= i_row;
            r_col    <= i_col;
            r_addend <= i_addend;
        end

        if (r_state == S_SETUP) begin
            r_ir       <= ir0[IW-1:0];
            r_ir_last  <= ir_end[IW-1:0];
            r_ic       <= ic0[IW-1:0];
            r_ic_first <= ic0[IW-1:0];
            r_ic_last  <= ic_end[IW-1:0];
            r_kr       <= kr0[KIW-1:0];
            r_kc       <= kc0[KIW-1:0];
            r_kc_first <= kc0[KIW-1:0];
        end else if (r_state == S_RUN) begin
            // The image column rises while the rotated kernel column falls;
            // at the end of a row both wrap and the rows step.
            if (r_ic == r_ic_last) begin
                r_ic <= r_ic_first;
                r_kc <= r_kc_first;
                r_ir <= r_ir + IW'(1);
                r_kr <= r_kr - KIW'(1);
            end else begin
                r_ic <= r_ic + IW'(1);
                r_kc <= r_kc - KIW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result: saturate the accumulated total once to 40 bits.
    // ------------------------------------------------------------------
    always_comb begin
        if (mac_acc > SAT_HI) begin
            sat_sum = SUM_MAX;
        end else if (mac_acc < SAT_LO) begin
            sat_sum = SUM_MIN;
        end else begin
            sat_sum = mac_acc[39:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ((r_state == S_SETUP) && pos_err)
                   || ((r_state == S_DRAIN) && !mac_busy);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SETUP) && pos_err) begin
            r_sum  <= '0;
            r_rerr <= 1'b1;
        end else if ((r_state == S_DRAIN) && !mac_busy) begin
            r_sum  <= sat_sum;
            r_rerr <= 1'b0;
        end
    end

    assign o_done        = r_done;
    assign o_sum         = r_sum;
    assign o_range_error = r_rerr;

    // ------------------------------------------------------------------
    // Stores and multiply-accumulate pipeline
    // ------------------------------------------------------------------
    c2d_mac #(
        .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM),
        .IMG_AW         (IMG_AW),
        .KER_AW         (KER_AW),
        .ACC_W          (ACC_W)
    ) u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (mac_ctrl),
        .i_img_wr_addr (img_wr_addr),
        .i_ker_wr_addr (ker_wr_addr),
        .i_wr_data     (i_sample),
        .i_img_rd_addr (img_rd_addr),
        .i_ker_rd_addr (ker_rd_addr),
        .i_acc_init    ({{(ACC_W-40){r_addend[39]}}, r_addend}),
        .o_acc         (mac_acc),
        .o_busy        (mac_busy)
    );

endmodule

[tb/tb_top.sv]
// ============================================================================
// tb_top: self-checking bench for the 2-D full/valid convolution block
// Fills the part of the image store that any window reads and the whole tap
// store, runs a directed set of edge cases, then random words under several
// register settings and sender idle rates. A scoreboard holds an independent
// fixed-point model of the stores and the clipped window sum and checks every
// result strobe against the oldest awaited result.
// ============================================================================
module tb_top
    import c2d_pkg::*;
();

    localparam int IMG_DIM        = 32;
    localparam int KER_DIM        = 8;
    // Pixels written up front: a square in the top left corner plus all of
    // column zero. Every setting below only reads inside that area.
    localparam int FILL_DIM       = 12;
    // A compute word reads at most 64 taps; the drain wait leaves room above that.
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_GAP        = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    // Code 3 is not an operation; the block must drop such a word.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [39:0] sum;
        logic               range_error;
    } t_conv_out;

    // Mirrors the stores and registers and predicts each compute result.
    class conv_scoreboard;
        logic signed [15:0] pixels [IMG_DIM][IMG_DIM];
        logic signed [15:0] taps   [KER_DIM][KER_DIM];
        logic               mode_q;
        logic [5:0]         img_h_q;
        logic [5:0]         img_w_q;
        logic [3:0]         ker_h_q;
        logic [3:0]         ker_w_q;
        t_conv_out          awaited_results [$];
        int                 mismatches;

        function new();
            mode_q     = RST_MODE;
            img_h_q    = RST_IMG_H;
            img_w_q    = RST_IMG_W;
            ker_h_q    = RST_KER_H;
            ker_w_q    = RST_KER_W;
            mismatches = 0;
        endfunction

        function int clamp_dim(int v, int hi);
            return (v < 1) ? 1 : ((v > hi) ? hi : v);
        endfunction

        function void set_register(logic [2:0] index, logic [5:0] data);
            case (index)
                CFG_MODE:  mode_q  = data[0];
                CFG_IMG_H: img_h_q = data;
                CFG_IMG_W: img_w_q = data;
                CFG_KER_H: ker_h_q = data[3:0];
                CFG_KER_W: ker_w_q = data[3:0];
                default:   ;
            endcase
        endfunction

        // Clamped dimensions in use and the size of the output region.
        function void geometry(output int h1, output int w1, output int h2,
                               output int w2, output int rows, output int cols);
            h1 = clamp_dim(img_h_q, IMG_DIM);
            w1 = clamp_dim(img_w_q, IMG_DIM);
            h2 = clamp_dim(ker_h_q, KER_DIM);
            w2 = clamp_dim(ker_w_q, KER_DIM);
            if (mode_q) begin
                rows = h1 + h2 - 1;
                cols = w1 + w2 - 1;
            end else begin
                rows = h1 - h2 + 1;
                cols = w1 - w2 + 1;
            end
        endfunction

        // Addend plus the edge-clipped sum of pixel times rotated tap.
        function t_conv_out clipped_window_sum(int row, int col,
                                               logic signed [39:0] addend);
            int        h1, w1, h2, w2, rows, cols, i, j, p, q;
            longint    acc;
            t_conv_out res;
            geometry(h1, w1, h2, w2, rows, cols);
            res.sum         = '0;
            res.range_error = 1'b1;
            if (row >= rows || col >= cols)
                return res;
            i   = mode_q ? row - (h2 - 1) : row;
            j   = mode_q ? col - (w2 - 1) : col;
            acc = longint'(addend);
            for (p = 0; p < h2; p++) begin
                for (q = 0; q < w2; q++) begin
                    if (i + p >= 0 && i + p < h1 && j + q >= 0 && j + q < w1)
                        acc += longint'(pixels[i + p][j + q])
                             * longint'(taps[h2 - p - 1][w2 - q - 1]);
                end
            end
            res.range_error = 1'b0;
            if (acc > longint'(SUM_MAX))
                res.sum = SUM_MAX;
            else if (acc < longint'(SUM_MIN))
                res.sum = SUM_MIN;
            else
                res.sum = 40'(acc);
            return res;
        endfunction

        function void note_word(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                logic signed [15:0] sample, logic signed [39:0] addend);
            case (op)
                OP_PIXEL: if (row < IMG_DIM && col < IMG_DIM) pixels[row][col] = sample;
                OP_TAP:   if (row < KER_DIM && col < KER_DIM) taps[row][col] = sample;
                OP_CONV:  awaited_results.push_back(clipped_window_sum(row, col, addend));
                default:  ;
            endcase
        endfunction

        function void check_output(logic signed [39:0] sum, logic range_error);
            t_conv_out want;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, sum %0d range_error %0b",
                         $time, sum, range_error);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (sum !== want.sum) begin
                $display("%0t: sum mismatch, expected %0d actual %0d",
                         $time, want.sum, sum);
                mismatches++;
            end
            if (range_error !== want.range_error) begin
                $display("%0t: range_error mismatch, expected %0b actual %0b",
                         $time, want.range_error, range_error);
                mismatches++;
            end
        endfunction
    endclass

    // All block inputs start at known values; reset is held from time zero.
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic [1:0]         i_op          = OP_PIXEL;
    logic [5:0]         i_row         = '0;
    logic [5:0]         i_col         = '0;
    logic signed [15:0] i_sample      = '0;
    logic signed [39:0] i_addend      = '0;
    logic               i_cfg_valid   = 1'b0;
    logic [2:0]         i_cfg_index   = CFG_MODE;
    logic [5:0]         i_cfg_data    = '0;
    logic               busy;
    logic               o_done;
    logic signed [39:0] o_sum;
    logic               o_range_error;
    logic               o_cfg_ready;

    conv_scoreboard sb;
    int             sender_idle_pct = 0;
    int             quiet_cycles    = 0;

    conv2d_full_valid_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_sample      (i_sample),
        .i_addend      (i_addend),
        .o_done        (o_done),
        .o_sum         (o_sum),
        .o_range_error (o_range_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Results are strobed for one cycle and cannot be held off, so every
    // strobe seen at a rising edge is checked right there. Values read here
    // are the ones from before the edge, since all drives are nonblocking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_output(o_sum, o_range_error);
    end

    // The watchdog counts edges at which no word, result or register write
    // moves. The longest correct quiet stretch is a sender gap, a full
    // 64-tap compute and the drain pause, well under the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1
                || (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL conv2d_full_valid_top");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_sample();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return 16'($urandom);
    endfunction

    // Presents one word and returns once it is accepted and busy is low. Start is
    // left high so that a following word can go out without a gap; it is
    // only lowered when the sender idles or a stretch of words ends.
    task automatic drive_word(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                              logic signed [15:0] sample, logic signed [39:0] addend);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_op     <= op;
        i_row    <= row;
        i_col    <= col;
        i_sample <= sample;
        i_addend <= addend;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_word(op, row, col, sample, addend);
    endtask

    // Lowers start and waits until every awaited result has come, then lets
    // the block finish any work that produces no result.
    task automatic settle();
        start <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five registers back to back with valid held high.
    task automatic write_config(logic [5:0] mode, logic [5:0] img_h, logic [5:0] img_w,
                                logic [5:0] ker_h, logic [5:0] ker_w);
        logic [2:0] index [5];
        logic [5:0] data [5];
        index = '{CFG_MODE, CFG_IMG_H, CFG_IMG_W, CFG_KER_H, CFG_KER_W};
        data  = '{mode, img_h, img_w, ker_h, ker_w};
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 5; k++) begin
            i_cfg_index <= index[k];
            i_cfg_data  <= data[k];
            @(posedge i_clk);
            while (o_cfg_ready !== 1'b1)
                @(posedge i_clk);
            sb.set_register(index[k], data[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One random word. Most compute words land inside the current output
    // region; the rest, and a few loads, use the full range of row and col.
    // The flag tells whether the block does anything with the word.
    task automatic random_word(output bit counted);
        int                 h1, w1, h2, w2, rows, cols, pick;
        logic [1:0]         op;
        logic [5:0]         row, col;
        logic signed [39:0] addend;
        sb.geometry(h1, w1, h2, w2, rows, cols);
        pick = $urandom_range(99);
        row  = 6'($urandom);
        col  = 6'($urandom);
        if (pick < 55) begin
            op = OP_CONV;
            if (rows > 0 && cols > 0 && $urandom_range(9) != 0) begin
                row = 6'($urandom_range(rows - 1));
                col = 6'($urandom_range(cols - 1));
            end
        end else if (pick < 75) begin
            op = OP_PIXEL;
            if ($urandom_range(7) != 0) begin
                row = 6'($urandom_range(IMG_DIM - 1));
                col = 6'($urandom_range(IMG_DIM - 1));
            end
        end else if (pick < 93) begin
            op = OP_TAP;
            if ($urandom_range(7) != 0) begin
                row = 6'($urandom_range(KER_DIM - 1));
                col = 6'($urandom_range(KER_DIM - 1));
            end
        end else begin
            op = OP_UNUSED;
        end
        // Addends near either rail drive the saturation logic.
        case ($urandom_range(3))
            0:       addend = 40'(signed'($urandom));
            1:       addend = SUM_MAX - 40'($urandom_range(1048575));
            2:       addend = SUM_MIN + 40'($urandom_range(1048575));
            default: addend = 40'({$urandom, $urandom});
        endcase
        drive_word(op, row, col, pick_sample(), addend);
        counted = (op == OP_CONV)
               || (op == OP_PIXEL && row < IMG_DIM && col < IMG_DIM)
               || (op == OP_TAP && row < KER_DIM && col < KER_DIM);
    endtask

    task automatic run_phase(int idle_pct, logic [5:0] mode, logic [5:0] img_h,
                             logic [5:0] img_w, logic [5:0] ker_h, logic [5:0] ker_w,
                             int words);
        int done_words;
        bit counted;
        write_config(mode, img_h, img_w, ker_h, ker_w);
        sender_idle_pct = idle_pct;
        done_words = 0;
        while (done_words < words) begin
            random_word(counted);
            if (counted)
                done_words++;
        end
        settle();
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every pixel and tap that a window can read is written before any
        // compute word, so no window ever reads an entry that holds no
        // defined value. The far corner pixel is written by a directed word.
        for (int r = 0; r < FILL_DIM; r++)
            for (int c = 0; c < FILL_DIM; c++)
                drive_word(OP_PIXEL, 6'(r), 6'(c), pick_sample(), '0);
        for (int r = FILL_DIM; r < IMG_DIM; r++)
            drive_word(OP_PIXEL, 6'(r), 6'd0, pick_sample(), '0);
        for (int r = 0; r < KER_DIM; r++)
            for (int c = 0; c < KER_DIM; c++)
                drive_word(OP_TAP, 6'(r), 6'(c), pick_sample(), '0);

        // Directed words under the reset setting: full mode, 32 by 32 image,
        // 3 by 3 kernel, so the output region is 34 by 34. At the corner the
        // window shrinks to the single product of pixel and tap at the origin.
        drive_word(OP_PIXEL, 6'd0, 6'd0, 16'sh8000, '0);
        drive_word(OP_TAP,   6'd0, 6'd0, 16'sh8000, '0);
        drive_word(OP_CONV,  6'd0, 6'd0, 16'sh0000, SUM_MAX);
        drive_word(OP_CONV,  6'd0, 6'd0, 16'sh0000, '0);
        drive_word(OP_TAP,   6'd0, 6'd0, 16'sh7FFF, '0);
        drive_word(OP_CONV,  6'd0, 6'd0, 16'sh0000, SUM_MIN);
        // Far corner of the region and an interior position with all taps.
        drive_word(OP_PIXEL, 6'd31, 6'd31, 16'sh7FFF, '0);
        drive_word(OP_TAP,   6'd2, 6'd2, 16'sh7FFF, '0);
        drive_word(OP_CONV,  6'd33, 6'd33, 16'sh0000, SUM_MAX);
        drive_word(OP_CONV,  6'd6, 6'd6, 16'sh0000, -40'sd1);
        // Positions just outside the region and at the top of the field.
        drive_word(OP_CONV,  6'd34, 6'd0, 16'sh0000, SUM_MAX);
        drive_word(OP_CONV,  6'd0, 6'd34, 16'sh0000, SUM_MIN);
        drive_word(OP_CONV,  6'd63, 6'd63, 16'sh0000, '0);
        // Loads outside their store and the unused code must leave no trace.
        drive_word(OP_PIXEL, 6'd40, 6'd3, 16'sh1234, '0);
        drive_word(OP_PIXEL, 6'd3, 6'd63, 16'sh1234, '0);
        drive_word(OP_TAP,   6'd8, 6'd0, 16'sh5678, '0);
        drive_word(OP_TAP,   6'd0, 6'd8, 16'sh5678, '0);
        drive_word(OP_UNUSED, 6'd0, 6'd0, 16'sh7FFF, SUM_MAX);
        drive_word(OP_CONV,  6'd0, 6'd0, 16'sh0000, '0);
        drive_word(OP_CONV,  6'd33, 6'd33, 16'sh0000, '0);
        settle();

        // Random phases: valid mode with the largest kernel, the smallest
        // full setting, a kernel taller than the image in valid mode (empty
        // region), out-of-range dimensions that must clamp, the smallest
        // valid setting, a random setting inside the filled area, and full
        // mode with the largest kernel.
        run_phase(88, 6'd0, 6'd12, 6'd12, 6'd8, 6'd8, 30);
        run_phase(0,  6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 35);
        run_phase(22, 6'd0, 6'd5, 6'd7, 6'd8, 6'd2, 30);
        run_phase(0,  6'd1, 6'd63, 6'd0, 6'd15, 6'd0, 35);
        run_phase(88, 6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 30);
        run_phase(22, 6'($urandom), 6'($urandom_range(FILL_DIM)),
                  6'($urandom_range(FILL_DIM)), 6'($urandom_range(15)),
                  6'($urandom_range(15)), 35);
        run_phase(0,  6'd1, 6'd12, 6'd12, 6'd8, 6'd8, 35);

        if (sb.mismatches == 0)
            $display("PASS conv2d_full_valid_top");
        else
            $display("FAIL conv2d_full_valid_top");
        $finish;
    end

endmodule

[sim.f]
rtl/core/c2d_pkg.sv
rtl/core/c2d_mac.sv
rtl/core/conv2d_full_valid_top.sv
tb/tb_top.sv
